### hdl/ubds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubds_pkg
// Types and constants shared by the baud divisor select block.
// ----------------------------------------------------------------------------
package ubds_pkg;

    localparam int CLK_W  = 29;
    localparam int RATE_W = 26;
    localparam int DIV_W  = 16;
    localparam int FRAC_W = 3;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_MAIN_CLOCK = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALT_CLOCK  = 2'd1;

    localparam logic [CLK_W-1:0] MAIN_CLOCK_RESET = 29'd150000000;
    localparam logic [CLK_W-1:0] ALT_CLOCK_RESET  = 29'd150000000;

    localparam logic KIND_USART = 1'b0;
    localparam logic KIND_UART  = 1'b1;

    localparam logic SRC_MAIN = 1'b0;
    localparam logic SRC_ALT  = 1'b1;

    // first divide: numerator, denominator, quotient widths
    localparam int N1_W = 33;
    localparam int D1_W = 30;
    localparam int Q1_W = 30;
    // second divide
    localparam int N2_W = 32;
    localparam int D2_W = 23;
    localparam int Q2_W = 26;

    typedef struct packed {
        logic              command;
        logic [RATE_W-1:0] link_rate;
    } in_t;

    typedef struct packed {
        logic              source_select;
        logic              oversample_by_8;
        logic [DIV_W-1:0]  divider;
        logic [FRAC_W-1:0] fraction;
        logic [RATE_W-1:0] rate_error;
    } out_t;

    typedef struct packed {
        logic              kind;
        logic [RATE_W-1:0] rate;
        logic [CLK_W-1:0]  clk_hz;
        logic              over8;
        logic              zero;
    } side1_t;

    typedef struct packed {
        logic              kind;
        logic [RATE_W-1:0] rate;
        logic              over8;
        logic [DIV_W-1:0]  div;
        logic [FRAC_W-1:0] frac;
    } side2_t;

endpackage

### hdl/ubds_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubds_div
// Pipelined restoring divider, one quotient bit per stage. Requires
// num < den * 2**QW. Sideband travels alongside the data.
// ----------------------------------------------------------------------------
module ubds_div #(
    parameter int NW = 33,
    parameter int DW = 30,
    parameter int QW = 30,
    parameter int SW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side,
    output logic          out_valid,
    output logic [QW-1:0] quot,
    output logic [SW-1:0] side_out
);

    logic          v_reg    [0:QW];
    logic [DW-1:0] rem_reg  [0:QW];
    logic [QW-1:0] n_reg    [0:QW];
    logic [QW-1:0] q_reg    [0:QW];
    logic [DW-1:0] den_reg  [0:QW];
    logic [SW-1:0] side_reg [0:QW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= DW'(num[NW-1:QW]);
        n_reg[0]    <= num[QW-1:0];
        q_reg[0]    <= '0;
        den_reg[0]  <= den;
        side_reg[0] <= side;
    end

    for (genvar s = 0; s < QW; s++)
    begin : g_stage
        logic [DW:0]   t;
        logic          ge;
        logic [DW:0]   diff;
        logic [DW-1:0] rem_next;

        always_comb
        begin
            t        = {rem_reg[s], n_reg[s][QW-1]};
            ge       = (t >= {1'b0, den_reg[s]});
            diff     = t - {1'b0, den_reg[s]};
            rem_next = ge ? diff[DW-1:0] : t[DW-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s+1] <= 1'b0;
            end
            else
            begin
                v_reg[s+1] <= v_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s+1]  <= rem_next;
            n_reg[s+1]    <= {n_reg[s][QW-2:0], 1'b0};
            q_reg[s+1]    <= {q_reg[s][QW-2:0], ge};
            den_reg[s+1]  <= den_reg[s];
            side_reg[s+1] <= side_reg[s];
        end
    end

    assign out_valid = v_reg[QW];
    assign quot      = q_reg[QW];
    assign side_out  = side_reg[QW];

endmodule

### hdl/uart_baud_divisor_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_baud_divisor_select
// Picks the source clock and divider giving the closest bit rate.
// ----------------------------------------------------------------------------
// A request is taken on any cycle with start high; busy never rises, so one
// request per cycle is sustained. Each request yields one result beat, marked
// by done for one cycle, after the entry register, two bit-serial divider
// pipelines in series (30 stages for the divider, 26 for the achieved-rate
// check, both clocks side by side), the error stage and the output register.
// Results cannot be held off. Clock registers are sampled on request entry.
module uart_baud_divisor_select #(
    parameter int DIVIDER_MIN       = 1,
    parameter int USART_DIVIDER_MAX = 65535,
    parameter int UART_DIVIDER_MAX  = 65535
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  ubds_pkg::in_t                       request,
    output logic                                done,
    output ubds_pkg::out_t                      result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ubds_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ubds_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam logic [ubds_pkg::Q1_W-1:0] MIN_Q   = ubds_pkg::Q1_W'(DIVIDER_MIN);
    localparam logic [ubds_pkg::Q1_W-1:0] UMAX_Q  = ubds_pkg::Q1_W'(USART_DIVIDER_MAX);
    localparam logic [ubds_pkg::Q1_W-1:0] PMAX_Q  = ubds_pkg::Q1_W'(UART_DIVIDER_MAX);

    logic [ubds_pkg::CLK_W-1:0] main_clk_reg;
    logic [ubds_pkg::CLK_W-1:0] alt_clk_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_clk_reg <= ubds_pkg::MAIN_CLOCK_RESET;
            alt_clk_reg  <= ubds_pkg::ALT_CLOCK_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == ubds_pkg::CFG_MAIN_CLOCK)
            begin
                main_clk_reg <= cfg_data[ubds_pkg::CLK_W-1:0];
            end
            if (cfg_index == ubds_pkg::CFG_ALT_CLOCK)
            begin
                alt_clk_reg <= cfg_data[ubds_pkg::CLK_W-1:0];
            end
        end
    end

    // entry register
    logic                        in_v_reg;
    ubds_pkg::in_t               in_reg;
    logic [ubds_pkg::CLK_W-1:0]  in_main_reg;
    logic [ubds_pkg::CLK_W-1:0]  in_alt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else
        begin
            in_v_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg      <= request;
        in_main_reg <= main_clk_reg;
        in_alt_reg  <= alt_clk_reg;
    end

    // first divide setup, per source
    function automatic void setup1(
        input  logic                        kind,
        input  logic [ubds_pkg::RATE_W-1:0] rate,
        input  logic [ubds_pkg::CLK_W-1:0]  ck,
        output logic [ubds_pkg::N1_W-1:0]   n,
        output logic [ubds_pkg::D1_W-1:0]   d,
        output ubds_pkg::side1_t            sb
    );
        logic                       os16;
        logic [ubds_pkg::D1_W-1:0]  osr;
        os16 = ({1'b0, ck} >= {rate, 4'b0});
        osr  = os16 ? {rate, 4'b0} : {1'b0, rate, 3'b0};
        if (kind == ubds_pkg::KIND_USART)
        begin
            n = ubds_pkg::N1_W'({ck, 3'b0}) + ubds_pkg::N1_W'(osr[ubds_pkg::D1_W-1:1]);
            d = osr;
        end
        else
        begin
            n = ubds_pkg::N1_W'(ck[ubds_pkg::CLK_W-1:4])
                + ubds_pkg::N1_W'(rate[ubds_pkg::RATE_W-1:1]);
            d = ubds_pkg::D1_W'(rate);
        end
        sb.kind   = kind;
        sb.rate   = rate;
        sb.clk_hz = ck;
        sb.over8  = (kind == ubds_pkg::KIND_USART) && !os16;
        sb.zero   = (rate == '0);
    endfunction

    logic [ubds_pkg::N1_W-1:0] n1_m, n1_a;
    logic [ubds_pkg::D1_W-1:0] d1_m, d1_a;
    ubds_pkg::side1_t          s1_m, s1_a;

    always_comb
    begin
        setup1(in_reg.command, in_reg.link_rate, in_main_reg, n1_m, d1_m, s1_m);
        setup1(in_reg.command, in_reg.link_rate, in_alt_reg, n1_a, d1_a, s1_a);
    end

    logic                      q1_v_m, q1_v_a;
    logic [ubds_pkg::Q1_W-1:0] q1_m, q1_a;
    ubds_pkg::side1_t          t1_m, t1_a;

    ubds_div #(.NW(ubds_pkg::N1_W), .DW(ubds_pkg::D1_W), .QW(ubds_pkg::Q1_W),
               .SW($bits(ubds_pkg::side1_t))) u_div1_main (
        .clk(clk), .rst_n(rst_n), .in_valid(in_v_reg), .num(n1_m), .den(d1_m),
        .side(s1_m), .out_valid(q1_v_m), .quot(q1_m), .side_out(t1_m)
    );

    ubds_div #(.NW(ubds_pkg::N1_W), .DW(ubds_pkg::D1_W), .QW(ubds_pkg::Q1_W),
               .SW($bits(ubds_pkg::side1_t))) u_div1_alt (
        .clk(clk), .rst_n(rst_n), .in_valid(in_v_reg), .num(n1_a), .den(d1_a),
        .side(s1_a), .out_valid(q1_v_a), .quot(q1_a), .side_out(t1_a)
    );

    // clamp and second divide setup
    function automatic logic [ubds_pkg::DIV_W-1:0] clampq(
        input logic [ubds_pkg::Q1_W-1:0] v,
        input logic [ubds_pkg::Q1_W-1:0] hi
    );
        logic [ubds_pkg::Q1_W-1:0] r;
        if (v < MIN_Q)
        begin
            r = MIN_Q;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        else
        begin
            r = v;
        end
        return r[ubds_pkg::DIV_W-1:0];
    endfunction

    function automatic void setup2(
        input  logic [ubds_pkg::Q1_W-1:0]  q,
        input  ubds_pkg::side1_t           si,
        output logic [ubds_pkg::N2_W-1:0]  n,
        output logic [ubds_pkg::D2_W-1:0]  d,
        output ubds_pkg::side2_t           so
    );
        logic [ubds_pkg::DIV_W-1:0]        dv;
        logic [ubds_pkg::FRAC_W-1:0]       fr;
        logic [ubds_pkg::DIV_W+ubds_pkg::FRAC_W-1:0] e8;
        if (si.kind == ubds_pkg::KIND_USART)
        begin
            if (si.zero)
            begin
                dv = UMAX_Q[ubds_pkg::DIV_W-1:0];
                fr = '1;
            end
            else
            begin
                dv = clampq(ubds_pkg::Q1_W'(q[ubds_pkg::Q1_W-1:3]), UMAX_Q);
                fr = q[2:0];
            end
            e8 = {dv, fr};
            d  = si.over8 ? {1'b0, e8, 3'b0} : {e8, 4'b0};
            n  = {si.clk_hz, 3'b0};
        end
        else
        begin
            dv = si.zero ? PMAX_Q[ubds_pkg::DIV_W-1:0] : clampq(q, PMAX_Q);
            fr = '0;
            e8 = '0;
            d  = ubds_pkg::D2_W'(dv);
            n  = ubds_pkg::N2_W'(si.clk_hz[ubds_pkg::CLK_W-1:4]) | ubds_pkg::N2_W'(e8);
        end
        so.kind  = si.kind;
        so.rate  = si.rate;
        so.over8 = si.over8;
        so.div   = dv;
        so.frac  = fr;
    endfunction

    logic [ubds_pkg::N2_W-1:0] n2_m, n2_a;
    logic [ubds_pkg::D2_W-1:0] d2_m, d2_a;
    ubds_pkg::side2_t          s2_m, s2_a;

    always_comb
    begin
        setup2(q1_m, t1_m, n2_m, d2_m, s2_m);
        setup2(q1_a, t1_a, n2_a, d2_a, s2_a);
    end

    logic                      q2_v_m, q2_v_a;
    logic [ubds_pkg::Q2_W-1:0] q2_m, q2_a;
    ubds_pkg::side2_t          t2_m, t2_a;

    ubds_div #(.NW(ubds_pkg::N2_W), .DW(ubds_pkg::D2_W), .QW(ubds_pkg::Q2_W),
               .SW($bits(ubds_pkg::side2_t))) u_div2_main (
        .clk(clk), .rst_n(rst_n), .in_valid(q1_v_m), .num(n2_m), .den(d2_m),
        .side(s2_m), .out_valid(q2_v_m), .quot(q2_m), .side_out(t2_m)
    );

    ubds_div #(.NW(ubds_pkg::N2_W), .DW(ubds_pkg::D2_W), .QW(ubds_pkg::Q2_W),
               .SW($bits(ubds_pkg::side2_t))) u_div2_alt (
        .clk(clk), .rst_n(rst_n), .in_valid(q1_v_a), .num(n2_a), .den(d2_a),
        .side(s2_a), .out_valid(q2_v_a), .quot(q2_a), .side_out(t2_a)
    );

    // error stage
    logic                        err_v_reg;
    logic [ubds_pkg::RATE_W-1:0] err_m_reg, err_a_reg;
    ubds_pkg::side2_t            e_m_reg, e_a_reg;
    logic [ubds_pkg::RATE_W-1:0] err_m_next, err_a_next;

    always_comb
    begin
        err_m_next = (t2_m.rate >= q2_m) ? t2_m.rate - q2_m : q2_m - t2_m.rate;
        err_a_next = (t2_a.rate >= q2_a) ? t2_a.rate - q2_a : q2_a - t2_a.rate;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_v_reg <= 1'b0;
        end
        else
        begin
            err_v_reg <= q2_v_m && q2_v_a;
        end
    end

    always_ff @(posedge clk)
    begin
        err_m_reg <= err_m_next;
        err_a_reg <= err_a_next;
        e_m_reg   <= t2_m;
        e_a_reg   <= t2_a;
    end

    // select and output register
    logic             sel;
    ubds_pkg::side2_t win;
    logic             done_reg;
    ubds_pkg::out_t   result_reg;
    ubds_pkg::out_t   result_next;

    always_comb
    begin
        if (e_m_reg.kind == ubds_pkg::KIND_USART)
        begin
            sel = (err_m_reg < err_a_reg) ? ubds_pkg::SRC_MAIN : ubds_pkg::SRC_ALT;
        end
        else
        begin
            sel = (err_m_reg <= err_a_reg) ? ubds_pkg::SRC_MAIN : ubds_pkg::SRC_ALT;
        end
        win = (sel == ubds_pkg::SRC_ALT) ? e_a_reg : e_m_reg;
        result_next.source_select   = sel;
        result_next.oversample_by_8 = win.over8;
        result_next.divider         = win.div;
        result_next.fraction        = win.frac;
        result_next.rate_error      = (sel == ubds_pkg::SRC_ALT) ? err_a_reg : err_m_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= err_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
